FILE: rtl/lpht_pkg.sv
// Shared types and constants of the linear probing hash table.
package lpht_pkg;

	localparam int KEY_W   = 32;
	localparam int YEAR_W  = 4;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 3;
	localparam int DIGIT_W = 4;

	// Operation codes; the unused code behaves as a lookup.
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] RES_OK        = 2'd0;
	localparam logic [STAT_W-1:0] RES_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] RES_PRESENT   = 2'd2;
	localparam logic [STAT_W-1:0] RES_FULL      = 2'd3;

	// Division by ten as a reciprocal multiply: floor(k * MUL / 2^SHIFT) == k / 10.
	localparam logic [KEY_W-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
	localparam int               DIV10_SHIFT = 35;

	typedef enum logic [1:0] {
		SLOT_EMPTY   = 2'd0,
		SLOT_USED    = 2'd1,
		SLOT_DELETED = 2'd2
	} slot_state_t;

	typedef struct packed {
		slot_state_t         state;
		logic [KEY_W-1:0]    key;
		logic [YEAR_W-1:0]   year;
	} entry_t;

endpackage

FILE: rtl/lpht_req_if.sv
// Request channel: operation, key and year level.
interface lpht_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [31:0] key;
	logic [3:0] year_level;

	modport source (output valid, output operation, output key, output year_level, input ready);
	modport sink (input valid, input operation, input key, input year_level, output ready);
endinterface

FILE: rtl/lpht_rsp_if.sv
// Response channel: status, found flag and slot index.
interface lpht_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       found;
	logic [2:0] slot;

	modport source (output valid, output status, output found, output slot, input ready);
	modport sink (input valid, input status, input found, input slot, output ready);
endinterface

FILE: rtl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/lpht_hash.sv
// Home slot unit: sums the decimal digits of a key, one digit per cycle, modulo the table size.
module lpht_hash #(
	parameter int TABLE_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lpht_pkg::KEY_W-1:0]     key,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] home
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int SUM_W = IDX_W + 1;
	localparam logic [SUM_W-1:0] SLOTS_SUM = SUM_W'(TABLE_SLOTS);

	logic                busy_q;
	logic [KEY_W-1:0]    k_q;
	logic [IDX_W-1:0]    sum_q;
	logic [2*KEY_W-1:0]  prod;
	logic [DIGIT_W-1:0]  quot_lo;
	logic [DIGIT_W-1:0]  quot_x10;
	logic [DIGIT_W-1:0]  digit;
	logic [SUM_W-1:0]    acc;
	logic [SUM_W-1:0]    acc_mod;
	logic [SUM_W-1:0]    dig_mod [2**DIGIT_W];

	// Each possible digit value reduced modulo the table size.
	for (genvar g = 0; g < 2**DIGIT_W; g++) begin : g_dig_mod
		assign dig_mod[g] = SUM_W'(g % TABLE_SLOTS);
	end

	assign prod     = (2*KEY_W)'(k_q) * (2*KEY_W)'(DIV10_MUL);
	assign quot_lo  = prod[DIV10_SHIFT +: DIGIT_W];
	// Only the low four bits of quotient times ten are needed for the remainder.
	assign quot_x10 = DIGIT_W'({quot_lo, 3'b000}) + DIGIT_W'({quot_lo, 1'b0});
	assign digit    = k_q[DIGIT_W-1:0] - quot_x10;
	assign acc      = {1'b0, sum_q} + dig_mod[digit];
	assign acc_mod  = (acc >= SLOTS_SUM) ? acc - SLOTS_SUM : acc;

	assign done = busy_q && (k_q == '0);
	assign home = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q   <= key;
			sum_q <= '0;
		end else if (busy_q && k_q != '0) begin
			k_q   <= KEY_W'(prod[2*KEY_W-1:DIV10_SHIFT]);
			sum_q <= IDX_W'(acc_mod);
		end
	end
endmodule

FILE: rtl/linear_probe_hash_table.sv
// Linear probing hash table with tombstones, held in one synchronous RAM.
//
//   channel | role   | payload                        | handshake
//   --------+--------+--------------------------------+-------------
//   req     | sink   | operation, key, year_level     | valid/ready
//   rsp     | source | status, found, slot            | valid/ready
//
// How long a request takes is set by the digit-sum unit and the single RAM read port,
// which reads one slot per cycle.
// After reset a clearing pass marks every slot empty; ready stays low meanwhile.
// Results leave through an output register, so a new request is taken while the
// previous result waits; a finished request holds until that register is free.
module linear_probe_hash_table #(
	parameter int TABLE_SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_PROBE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    clr_idx_q;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [YEAR_W-1:0]   year_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    iss_cnt_q;
	logic [IDX_W-1:0]    eval_cnt_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                rsp_valid_q;
	logic [STAT_W-1:0]   rsp_status_q;
	logic                rsp_found_q;
	logic [SLOT_W-1:0]   rsp_slot_q;

	logic                req_acc;
	logic                hash_done;
	logic [IDX_W-1:0]    hash_home;
	logic                rd_en;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t              rd_entry;
	logic                probe_hit;
	logic                probe_empty;
	logic                probe_free;
	logic                probe_last;
	logic                probe_stop;
	logic                out_free;
	logic                finish;
	logic [STAT_W-1:0]   res_status;
	logic [IDX_W-1:0]    res_idx;
	logic                upd_en;
	logic [IDX_W-1:0]    upd_idx;
	entry_t              upd_entry;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	entry_t              ram_wdata;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	lpht_hash #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_acc),
		.key    (req.key),
		.done   (hash_done),
		.home   (hash_home)
	);

	lpht_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Reads are issued one slot per cycle ahead of evaluation; reads past the stop are dropped.
	assign rd_en       = (state_q == S_PROBE) && (iss_cnt_q != SLOTS_CNT);
	assign rd_entry    = entry_t'(ram_rdata);
	assign probe_hit   = vld_s1 && rd_entry.state == SLOT_USED && rd_entry.key == key_q;
	assign probe_empty = vld_s1 && rd_entry.state == SLOT_EMPTY;
	assign probe_free  = vld_s1 && rd_entry.state != SLOT_USED;
	assign probe_last  = vld_s1 && eval_cnt_q == LAST_IDX;
	assign probe_stop  = probe_hit || probe_empty || probe_last;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign finish   = (state_q == S_DONE) && out_free;

	always_comb begin
		res_status = RES_NOT_FOUND;
		res_idx    = '0;
		upd_en     = 1'b0;
		upd_idx    = free_idx_q;
		upd_entry  = '{state: SLOT_USED, key: key_q, year: year_q};
		unique case (op_q)
			OP_INSERT: begin
				priority if (hit_q) begin
					res_status = RES_PRESENT;
					res_idx    = hit_idx_q;
				end else if (free_found_q) begin
					res_status = RES_OK;
					res_idx    = free_idx_q;
					upd_en     = 1'b1;
				end else begin
					res_status = RES_FULL;
				end
			end
			OP_DELETE: begin
				if (hit_q) begin
					res_status      = RES_OK;
					res_idx         = hit_idx_q;
					upd_en          = 1'b1;
					upd_idx         = hit_idx_q;
					upd_entry.state = SLOT_DELETED;
				end
			end
			default: begin
				if (hit_q) begin
					res_status = RES_OK;
					res_idx    = hit_idx_q;
				end
			end
		endcase
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_idx_q;
			ram_wdata = '{state: SLOT_EMPTY, key: '0, year: '0};
		end else begin
			ram_we    = finish && upd_en;
			ram_waddr = upd_idx;
			ram_wdata = upd_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			iss_cnt_q    <= '0;
			eval_cnt_q   <= '0;
			vld_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_en && !probe_stop;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						iss_cnt_q    <= '0;
						eval_cnt_q   <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (rd_en) begin
						iss_cnt_q <= iss_cnt_q + 1'b1;
					end
					if (vld_s1) begin
						eval_cnt_q <= eval_cnt_q + 1'b1;
					end
					if (probe_free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (probe_stop) begin
						hit_q   <= probe_hit;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (req_acc) begin
			op_q   <= req.operation;
			key_q  <= req.key;
			year_q <= req.year_level;
		end
		if (state_q == S_HASH && hash_done) begin
			rd_idx_q <= hash_home;
		end else if (rd_en) begin
			rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
		end
		if (state_q == S_PROBE && probe_free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == S_PROBE && probe_stop) begin
			hit_idx_q <= idx_s1;
		end
		if (finish) begin
			rsp_status_q <= res_status;
			rsp_found_q  <= hit_q;
			rsp_slot_q   <= SLOT_W'(res_idx);
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.found  = rsp_found_q;
	assign rsp.slot   = rsp_slot_q;
endmodule

FILE: rtl/lpht_chk.sv
// Port-level checker for the hash table, attached to the top level by bind.
module lpht_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [lpht_pkg::STAT_W-1:0]  rsp_status,
	input logic                         rsp_found,
	input logic [lpht_pkg::SLOT_W-1:0]  rsp_slot
);
	import lpht_pkg::*;

	logic [1:0] pend_q;

	// Requests taken whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_found) && $stable(rsp_slot))
		else $error("response changed while stalled");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q == 2'd1 || pend_q == 2'd2))
		else $error("response without an outstanding request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> (pend_q == 2'd0 || pend_q == 2'd1))
		else $error("second request taken before the first result was registered");

	a_miss_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == RES_NOT_FOUND || rsp_status == RES_FULL) |->
			!rsp_found && rsp_slot == '0)
		else $error("miss or full result carries a slot or found flag");

	a_present_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == RES_PRESENT |-> rsp_found)
		else $error("already-present result without found flag");
endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_found  (rsp.found),
	.rsp_slot   (rsp.slot)
);
